### sv/chained_hash_set_macros.svh
// assertion macros shared by the hash set modules
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHS_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hash set assertion failed");

// next-cycle implication, disabled during reset
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hash set assertion failed");

`endif

### sv/chs_pkg.sv
// shared types and constants of the chained hash set
package chs_pkg;

	localparam int KEY_W   = 32;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 9;
	localparam int CFG_W   = 7;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_CONTAINS = 2'd0,
		OP_INSERT   = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic               status;
		logic [COUNT_W-1:0] key_count;
	} rsp_t;

endpackage

### sv/chs_if.sv
// request and response channel interfaces of the chained hash set
interface chs_req_if;
	logic                                valid;
	logic                                ready;
	logic [chs_pkg::OP_W-1:0]            op;
	logic signed [chs_pkg::KEY_W-1:0]    key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

interface chs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                hit;
	logic                                status;
	logic [chs_pkg::COUNT_W-1:0]         key_count;

	modport source (output valid, output hit, output status, output key_count, input ready);
	modport sink (input valid, input hit, input status, input key_count, output ready);
endinterface

### sv/chained_hash_set.sv
// top level of the chained hash set
// Hash set of signed 32-bit keys in BUCKETS buckets of WAYS entries each.
// req channel (valid/ready): op (0 contains, 1 insert, 2 remove, 3 none)
// and key; a transfer happens when valid and ready are both high.
// rsp channel (valid/ready): hit, status (insert refused, bucket full) and
// key_count, one response per request, in request order.
// cfg_we/cfg_wdata write bucket_count; write only while the block is idle.
// The front computes key mod bucket_count with a one-bit-per-cycle divider:
// it accepts a request, runs the divide steps and hands the result to the
// queue, and takes no new request until that hand-off is done.
// The back reads the bucket row through the ram's registered read, then
// compares all ways and writes the row back once the response register is
// free; rsp.valid is driven from that register.
// After reset the table is cleared one bucket per cycle (all BUCKETS buckets,
// 64 by default); req.ready stays low until that is done. bucket_count
// resets to 64 and the key count to zero.
// A stalled rsp holds the response in its output register; the front keeps
// hashing into a two-entry queue and stops accepting once that is full.
module chained_hash_set #(
	parameter int BUCKETS = 64,
	parameter int WAYS    = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	chs_req_if.sink                       req,
	chs_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [chs_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW = $bits(chs_pkg::req_t) + BW;

	logic [chs_pkg::CFG_W-1:0] bucket_count_q;
	logic                      init_done;

	logic                      fq_valid;
	logic                      fq_ready;
	chs_pkg::req_t             fq_req;
	logic [BW-1:0]             fq_bucket;

	logic                      qb_valid;
	logic                      qb_ready;
	logic [QW-1:0]             qb_data;
	chs_pkg::req_t             qb_req;
	logic [BW-1:0]             qb_bucket;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= chs_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	chs_front #(
		.BUCKETS (BUCKETS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.bucket_count (bucket_count_q),
		.enable       (init_done),
		.q_valid      (fq_valid),
		.q_ready      (fq_ready),
		.q_req        (fq_req),
		.q_bucket     (fq_bucket)
	);

	chs_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   ({fq_req, fq_bucket}),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	assign {qb_req, qb_bucket} = qb_data;

	chs_back #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_req     (qb_req),
		.q_bucket  (qb_bucket),
		.rsp       (rsp),
		.init_done (init_done)
	);

endmodule

### sv/chs_ram.sv
// generic single-port-write ram with registered read
module chs_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [W-1:0]                          wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [W-1:0]                          rd_data
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/chs_front.sv
// request intake and bucket hash by iterative restoring modulo
`include "chained_hash_set_macros.svh"

module chs_front #(
	parameter int BUCKETS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	chs_req_if.sink                               req,
	input  logic [chs_pkg::CFG_W-1:0]             bucket_count,
	input  logic                                  enable,
	output logic                                  q_valid,
	input  logic                                  q_ready,
	output chs_pkg::req_t                         q_req,
	output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] q_bucket
);

	localparam int KW   = chs_pkg::KEY_W;
	localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int MW   = $clog2(BUCKETS + 1);
	localparam int CMPW = (MW > chs_pkg::CFG_W) ? MW : chs_pkg::CFG_W;
	localparam int CTW  = $clog2(KW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	state_t           state_q;
	logic [CTW-1:0]   cnt_q;
	chs_pkg::req_t    req_q;
	logic [KW-1:0]    mag_q;
	logic             neg_q;
	logic [MW-1:0]    m_q;
	logic [MW-1:0]    rem_q;

	logic             accept;
	logic [KW-1:0]    mag_d;
	logic [MW-1:0]    m_d;
	logic [CMPW-1:0]  cfg_ext;
	logic [MW:0]      trial;
	logic [MW:0]      trial_sub;
	logic [MW-1:0]    rem_d;
	logic [MW-1:0]    bucket_full;

	assign req.ready = (state_q == ST_IDLE) && enable;
	assign accept    = req.valid && req.ready;

	// effective modulus: zero means one, capped at BUCKETS
	always_comb begin
		cfg_ext = CMPW'(bucket_count);
		if (bucket_count == '0) begin
			m_d = MW'(1);
		end else if (cfg_ext > CMPW'(BUCKETS)) begin
			m_d = MW'(BUCKETS);
		end else begin
			m_d = MW'(bucket_count);
		end
	end

	assign mag_d = req.key[KW-1] ? (~$unsigned(req.key) + KW'(1)) : $unsigned(req.key);

	// one quotient bit per cycle
	assign trial     = {rem_q, mag_q[KW-1]};
	assign trial_sub = trial - {1'b0, m_q};
	assign rem_d     = (trial >= {1'b0, m_q}) ? trial_sub[MW-1:0] : trial[MW-1:0];

	// negative keys fold onto the non-negative residue
	assign bucket_full = (neg_q && (rem_q != '0)) ? (m_q - rem_q) : rem_q;

	assign q_valid  = (state_q == ST_PUSH);
	assign q_req    = req_q;
	assign q_bucket = BW'(bucket_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CTW'(1);
					if (cnt_q == CTW'(KW - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (q_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op  <= chs_pkg::op_t'(req.op);
			req_q.key <= req.key;
			mag_q     <= mag_d;
			neg_q     <= req.key[KW-1];
			m_q       <= m_d;
			rem_q     <= '0;
		end else if (state_q == ST_DIV) begin
			mag_q <= {mag_q[KW-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	`CHS_ASSERT(a_rem_below_mod, clk, arst_n, state_q == ST_DIV, rem_q < m_q)
	`CHS_ASSERT(a_bucket_below_mod, clk, arst_n, q_valid, bucket_full < m_q)
	`CHS_ASSERT_NEXT(a_accept_starts_div, clk, arst_n, accept, state_q == ST_DIV)

endmodule

### sv/chs_queue.sv
// two-entry queue between hash front and table back
module chs_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int DEPTH = 2;

	logic [W-1:0] entry_q [DEPTH];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;
	logic         push;
	logic         pop;

	assign in_ready  = (fill_q != 2'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

### sv/chs_back.sv
// bucket read-compare-write, key counter and response register
`include "chained_hash_set_macros.svh"

module chs_back #(
	parameter int BUCKETS = 64,
	parameter int WAYS    = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	output logic                                  q_ready,
	input  chs_pkg::req_t                         q_req,
	input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] q_bucket,
	chs_rsp_if.source                             rsp,
	output logic                                  init_done
);

	localparam int KW    = chs_pkg::KEY_W;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = WAYS * (KW + 1);
	localparam int CNT_W = $clog2(BUCKETS * WAYS + 1);
	localparam int VOFF  = WAYS * KW;

	typedef enum logic [2:0] {
		ST_INIT = 3'b001,
		ST_IDLE = 3'b010,
		ST_EVAL = 3'b100
	} state_t;

	state_t                 state_q;
	logic [BW-1:0]          clr_q;
	logic [CNT_W-1:0]       count_q;
	chs_pkg::req_t          item_q;
	logic [BW-1:0]          bucket_q;
	logic                   rsp_valid_q;
	chs_pkg::rsp_t          rsp_q;

	logic                   pop;
	logic                   commit;
	logic                   rd_en;
	logic [ROW_W-1:0]       rd_data;
	logic                   wr_en;
	logic [BW-1:0]          wr_addr;
	logic [ROW_W-1:0]       wr_data;

	logic [WAYS-1:0]        valid_v;
	logic [WAYS-1:0]        match_v;
	logic [WW-1:0]          match_idx;
	logic [WW-1:0]          free_idx;
	logic                   found;
	logic                   has_free;
	logic [ROW_W-1:0]       new_row;
	logic                   row_we;
	logic                   hit_d;
	logic                   status_d;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W+chs_pkg::COUNT_W-1:0] count_ext;

	assign init_done = (state_q != ST_INIT);
	assign q_ready   = (state_q == ST_IDLE);
	assign pop       = q_valid && q_ready;
	assign commit    = (state_q == ST_EVAL) && (!rsp_valid_q || rsp.ready);
	assign rd_en     = pop;

	chs_ram #(
		.W     (ROW_W),
		.DEPTH (BUCKETS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (q_bucket),
		.rd_data (rd_data)
	);

	// way search over the bucket row
	always_comb begin
		valid_v   = rd_data[VOFF +: WAYS];
		match_idx = '0;
		free_idx  = '0;
		for (int w = 0; w < WAYS; w++) begin
			match_v[w] = valid_v[w] && (rd_data[w*KW +: KW] == item_q.key);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match_v[w]) begin
				match_idx = WW'(w);
			end
			if (!valid_v[w]) begin
				free_idx = WW'(w);
			end
		end
		found    = |match_v;
		has_free = ~&valid_v;
	end

	always_comb begin
		new_row  = rd_data;
		row_we   = 1'b0;
		hit_d    = 1'b0;
		status_d = 1'b0;
		count_d  = count_q;
		unique case (item_q.op)
			chs_pkg::OP_CONTAINS: begin
				hit_d = found;
			end
			chs_pkg::OP_INSERT: begin
				if (!found) begin
					if (has_free) begin
						new_row[int'(free_idx)*KW +: KW] = item_q.key;
						new_row[VOFF + int'(free_idx)]   = 1'b1;
						row_we  = 1'b1;
						hit_d   = 1'b1;
						count_d = count_q + CNT_W'(1);
					end else begin
						status_d = 1'b1;
					end
				end
			end
			chs_pkg::OP_REMOVE: begin
				if (found) begin
					new_row[VOFF + int'(match_idx)] = 1'b0;
					row_we = 1'b1;
					hit_d  = 1'b1;
					if (count_q != '0) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			chs_pkg::OP_NOP: begin
				hit_d = 1'b0;
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
	end

	assign count_ext = {{chs_pkg::COUNT_W{1'b0}}, count_d};

	// clearing pass writes zero rows, then bucket updates
	always_comb begin
		if (state_q == ST_INIT) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = commit && row_we;
			wr_addr = bucket_q;
			wr_data = new_row;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.hit       = rsp_q.hit;
	assign rsp.status    = rsp_q.status;
	assign rsp.key_count = rsp_q.key_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (commit) begin
						count_q <= count_d;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q   <= q_req;
			bucket_q <= q_bucket;
		end
		if (commit) begin
			rsp_q.hit       <= hit_d;
			rsp_q.status    <= status_d;
			rsp_q.key_count <= count_ext[chs_pkg::COUNT_W-1:0];
		end
	end

	`CHS_ASSERT(a_no_pop_in_init, clk, arst_n, state_q == ST_INIT, !pop)
	`CHS_ASSERT(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(BUCKETS * WAYS))
	`CHS_ASSERT(a_hit_excl_status, clk, arst_n, rsp_valid_q, !(rsp_q.hit && rsp_q.status))

endmodule
